/* rtl/owk_pkg.sv */
// ----------------------------------------------------------------------------
// owk_pkg
// Shared constants, types and the quarter-wave sine table of the
// three-wheel omnidirectional kinematics engine.
// ----------------------------------------------------------------------------
package owk_pkg;

  localparam int DATA_WIDTH       = 32;
  localparam int FRAC_BITS        = 16;
  localparam int Q30_SHIFT        = 30;
  localparam int ANGLE_BITS       = 16;
  localparam int QUARTER_BITS     = ANGLE_BITS - 2;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int TAB_IDX_W        = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int POS_W            = QUARTER_BITS + 1 + TAB_IDX_W;
  localparam int TAB_W            = 32;

  localparam int ACT_W      = 3;
  localparam int HEAD_W     = 16;
  localparam int REG_W      = 31;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam int INT_W = 52;
  localparam int MA_W  = 35;
  localparam int MB_W  = 31;

  localparam logic [QUARTER_BITS:0] QUARTER = (QUARTER_BITS + 1)'(1) << QUARTER_BITS;

  localparam logic [MB_W-1:0] PI_HALF_Q30    = 31'd1686629713;
  localparam logic [MB_W-1:0] INV_SQRT3_Q30  = 31'd619925131;
  localparam logic [MB_W-1:0] SQRT3_HALF_Q30 = 31'd929887697;
  localparam logic [MB_W-1:0] HALF_Q30       = 31'd536870912;

  localparam logic [REG_W-1:0] WHEEL_DISTANCE_RST = 31'd65536;
  localparam logic [REG_W-1:0] RECIP_THREE_RST    = 31'd21845;

  localparam logic [ACT_W-1:0] ACT_FWD_BODY    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_FWD_WORLD   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INV_BODY    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_INV_WORLD   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_TO_WORLD    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_TO_BODY     = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SET_HEADING = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_DISTANCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECIP_THREE    = 1'b1;

  typedef struct packed {
    logic            neg;
    logic [MB_W-1:0] mag;
  } sgn_mag_t;

  typedef struct packed {
    logic            div;
    logic            a_neg;
    logic [MA_W-1:0] a_mag;
    logic            b_neg;
    logic [MB_W-1:0] b_mag;
    logic            shift_frac;
  } mul_req_t;

  typedef logic [TAB_W-1:0] sine_tab_t [SINE_TABLE_DEPTH+1];

  function automatic sine_tab_t build_sine();
    sine_tab_t          tab;
    logic [63:0]        x;
    logic [63:0]        t;
    logic signed [63:0] s;
    int                 i;
    int                 k;
    for (i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x = 64'(PI_HALF_Q30) * 64'(i) / 64'(SINE_TABLE_DEPTH);
      t = x;
      s = signed'(x);
      for (k = 1; k <= 7; k++) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        t = t / 64'((2 * k) * (2 * k + 1));
        if (k[0]) begin
          s = s - signed'(t);
        end else begin
          s = s + signed'(t);
        end
      end
      if (s < 0) begin
        s = '0;
      end
      if (s > 64'sd1073741824) begin
        s = 64'sd1073741824;
      end
      if (i > 0) begin
        if (s[TAB_W-1:0] < tab[i-1]) begin
          s = signed'(64'(tab[i-1]));
        end
      end
      tab[i] = s[TAB_W-1:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

/* rtl/owk_in_if.sv */
// ----------------------------------------------------------------------------
// owk_in_if
// Request channel carrying one kinematics action and its operands.
// ----------------------------------------------------------------------------
interface owk_in_if import owk_pkg::*; ;
  logic                         valid;
  logic                         ready;
  logic [ACT_W-1:0]             action;
  logic signed [DATA_WIDTH-1:0] operand_a;
  logic signed [DATA_WIDTH-1:0] operand_b;
  logic signed [DATA_WIDTH-1:0] operand_c;
  logic [HEAD_W-1:0]            new_heading;

  modport source (output valid, action, operand_a, operand_b, operand_c, new_heading,
                  input ready);
  modport sink   (input valid, action, operand_a, operand_b, operand_c, new_heading,
                  output ready);
endinterface

/* rtl/owk_out_if.sv */
// ----------------------------------------------------------------------------
// owk_out_if
// Result channel carrying three saturated values and the clip flag.
// ----------------------------------------------------------------------------
interface owk_out_if import owk_pkg::*; ;
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] result_a;
  logic signed [DATA_WIDTH-1:0] result_b;
  logic signed [DATA_WIDTH-1:0] result_c;
  logic                         saturated;

  modport source (output valid, result_a, result_b, result_c, saturated, input ready);
  modport sink   (input valid, result_a, result_b, result_c, saturated, output ready);
endinterface

/* rtl/owk_cfg_if.sv */
// ----------------------------------------------------------------------------
// owk_cfg_if
// Register write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface owk_cfg_if import owk_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/owk_serial_mul.sv */
// ----------------------------------------------------------------------------
// owk_serial_mul
// Bit-serial sign-magnitude multiplier with round-half-away scaling, which
// also performs a rounded divide by three one quotient bit per cycle.
// ----------------------------------------------------------------------------
module owk_serial_mul import owk_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  mul_req_t                req_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic signed [INT_W-1:0] result_o
);

  localparam int CNT_W = $clog2(MA_W + 1);
  localparam int PW    = MA_W + MB_W;
  localparam int QW    = INT_W - 1;
  localparam logic [PW:0] RND_FRAC = (PW + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [PW:0] RND_Q30  = (PW + 1)'(1) << (Q30_SHIFT - 1);

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_RUN  = 4'b0010,
    M_RND  = 4'b0100,
    M_NEG  = 4'b1000
  } mstate_e;

  mstate_e          st_q;
  logic [CNT_W-1:0] cnt_q;
  logic [MA_W-1:0]  hi_q;
  logic [MB_W-1:0]  lo_q;
  logic [MA_W-1:0]  a_q;
  logic [1:0]       rem_q;
  logic             div_q;
  logic             neg_q;
  logic             sh_q;
  logic [QW-1:0]    q_q;

  logic [MA_W:0]         add;
  logic [2:0]            dt;
  logic                  dge;
  logic [1:0]            drem;
  logic [PW:0]           rnd;
  logic [PW:0]           rq;
  logic signed [INT_W-1:0] qs;

  always_comb begin
    add  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);
    dt   = {rem_q, a_q[MA_W-1]};
    dge  = dt >= 3'd3;
    drem = dge ? 2'(dt - 3'd3) : dt[1:0];
    rnd  = {1'b0, hi_q, lo_q} + (sh_q ? RND_FRAC : RND_Q30);
    rq   = sh_q ? (rnd >> FRAC_BITS) : (rnd >> Q30_SHIFT);
    qs   = signed'({1'b0, q_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= M_IDLE;
      cnt_q <= '0;
    end else begin
      case (st_q)
        M_IDLE: begin
          if (start_i) begin
            st_q  <= M_RUN;
            cnt_q <= req_i.div ? CNT_W'(MA_W) : CNT_W'(MB_W);
          end
        end
        M_RUN: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CNT_W'(1)) begin
            st_q <= M_RND;
          end
        end
        M_RND:   st_q <= M_NEG;
        M_NEG:   st_q <= M_IDLE;
        default: st_q <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      M_IDLE: begin
        if (start_i) begin
          a_q   <= req_i.a_mag;
          lo_q  <= req_i.b_mag;
          hi_q  <= '0;
          rem_q <= '0;
          div_q <= req_i.div;
          neg_q <= req_i.a_neg ^ req_i.b_neg;
          sh_q  <= req_i.shift_frac;
        end
      end
      M_RUN: begin
        if (div_q) begin
          a_q   <= a_q << 1;
          hi_q  <= {hi_q[MA_W-2:0], dge};
          rem_q <= drem;
        end else begin
          hi_q <= add[MA_W:1];
          lo_q <= {add[0], lo_q[MB_W-1:1]};
        end
      end
      M_RND: begin
        if (div_q) begin
          q_q <= QW'(hi_q) + QW'(rem_q == 2'd2);
        end else begin
          q_q <= rq[QW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign busy_o   = st_q != M_IDLE;
  assign done_o   = st_q == M_NEG;
  assign result_o = neg_q ? -qs : qs;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> st_q == M_IDLE) else $error("start while busy");
  a_start_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> st_q == M_RUN) else $error("start did not launch");
  a_last_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == M_RUN && cnt_q == CNT_W'(1)) |=> st_q == M_RND) else $error("bit count");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> st_q == M_IDLE) else $error("done not followed by idle");

endmodule

/* rtl/omni_wheel_kinematics_top.sv */
// ----------------------------------------------------------------------------
// omni_wheel_kinematics_top
// Kinematics engine for a three-wheel omnidirectional base: forward and
// inverse kinematics in body or world frame and frame rotation by heading.
// ----------------------------------------------------------------------------
// Every product and the divide by three go through the one bit-serial unit,
// one after another; setting the heading does not use that unit.
// Throughput: one request at a time, the next is taken once the current
// result is in the output register. Reset restores both registers, heading 0.
// ----------------------------------------------------------------------------
module omni_wheel_kinematics_top import owk_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  owk_cfg_if.sink    cfg_i,
  owk_in_if.sink     in_i,
  owk_out_if.source  out_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_HEAD  = 6'b000010,
    S_ISSUE = 6'b000100,
    S_WAIT  = 6'b001000,
    S_FIN   = 6'b010000,
    S_SAT   = 6'b100000
  } state_e;

  typedef enum logic [3:0] {
    U_DIV, U_INV, U_RTD, U_XC, U_XS, U_YC, U_YS, U_HX, U_SY, U_LW, U_DONE
  } uop_e;

  state_e                  st_q;
  logic [ACT_W-1:0]        act_q;
  logic [2:0]              step_q;
  logic                    hph_q;
  logic [ANGLE_BITS-1:0]   heading_q;
  sgn_mag_t                sin_q;
  sgn_mag_t                cos_q;
  logic [REG_W-1:0]        wd_q;
  logic [REG_W-1:0]        rtd_q;
  logic signed [INT_W-1:0] u_q, v_q, w_q;
  logic signed [INT_W-1:0] pr_q [3];
  logic signed [INT_W-1:0] mr_q [4];
  logic signed [INT_W-1:0] ra_q, rb_q, rc_q;
  logic                    ov_q;
  logic [DATA_WIDTH-1:0]   oa_q, ob_q, oc_q;
  logic                    osat_q;

  uop_e                    uop;
  logic signed [INT_W-1:0] rot_x, rot_y, x_eff, y_eff, opv, opabs;
  logic signed [INT_W-1:0] ra_d, rb_d, rc_d;
  sgn_mag_t                bval;
  logic                    shf, dst_m;
  logic [1:0]              dix;
  mul_req_t                mreq;
  logic                    mu_start, mu_busy, mu_done;
  logic signed [INT_W-1:0] mu_res;
  logic                    in_acc, out_free;
  logic [DATA_WIDTH:0]     sat_a, sat_b, sat_c;

  function automatic sgn_mag_t sine_of(input logic [ANGLE_BITS-1:0] ang);
    logic [QUARTER_BITS:0]            w;
    logic [POS_W-1:0]                 pos;
    logic [TAB_IDX_W-1:0]             idx;
    logic [TAB_IDX_W-1:0]             idx1;
    logic [QUARTER_BITS-1:0]          frac;
    logic [TAB_W-1:0]                 t0;
    logic [TAB_W-1:0]                 t1;
    logic [TAB_W+QUARTER_BITS-1:0]    prod;
    logic [TAB_W-1:0]                 val;
    sgn_mag_t                         r;
    w = {1'b0, ang[QUARTER_BITS-1:0]};
    if (ang[QUARTER_BITS]) begin
      w = QUARTER - w;
    end
    pos  = POS_W'(w) * POS_W'(SINE_TABLE_DEPTH);
    idx  = TAB_IDX_W'(pos >> QUARTER_BITS);
    frac = pos[QUARTER_BITS-1:0];
    idx1 = (idx == TAB_IDX_W'(SINE_TABLE_DEPTH)) ? idx : idx + 1'b1;
    t0   = SINE_TAB[idx];
    t1   = SINE_TAB[idx1];
    prod = (TAB_W + QUARTER_BITS)'(t1 - t0) * (TAB_W + QUARTER_BITS)'(frac);
    val  = t0 + TAB_W'(prod >> QUARTER_BITS);
    r.neg = ang[ANGLE_BITS-1];
    r.mag = val[MB_W-1:0];
    return r;
  endfunction

  function automatic logic [DATA_WIDTH:0] sat_fn(input logic signed [INT_W-1:0] v);
    logic                  fits;
    logic [DATA_WIDTH-1:0] o;
    fits = (&v[INT_W-1:DATA_WIDTH-1]) | ~(|v[INT_W-1:DATA_WIDTH-1]);
    if (fits) begin
      o = v[DATA_WIDTH-1:0];
    end else if (v[INT_W-1]) begin
      o = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
    end else begin
      o = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    end
    return {~fits, o};
  endfunction

  assign in_i.ready  = st_q == S_IDLE;
  assign in_acc      = in_i.valid & in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_free    = !ov_q || out_o.ready;

  always_comb begin
    case (act_q)
      ACT_FWD_BODY: begin
        case (step_q)
          3'd0:    uop = U_DIV;
          3'd1:    uop = U_INV;
          3'd2:    uop = U_RTD;
          default: uop = U_DONE;
        endcase
      end
      ACT_FWD_WORLD: begin
        case (step_q)
          3'd0:    uop = U_DIV;
          3'd1:    uop = U_INV;
          3'd2:    uop = U_RTD;
          3'd3:    uop = U_XC;
          3'd4:    uop = U_XS;
          3'd5:    uop = U_YC;
          3'd6:    uop = U_YS;
          default: uop = U_DONE;
        endcase
      end
      ACT_INV_BODY: begin
        case (step_q)
          3'd0:    uop = U_HX;
          3'd1:    uop = U_SY;
          3'd2:    uop = U_LW;
          default: uop = U_DONE;
        endcase
      end
      ACT_INV_WORLD: begin
        case (step_q)
          3'd0:    uop = U_XC;
          3'd1:    uop = U_XS;
          3'd2:    uop = U_YC;
          3'd3:    uop = U_YS;
          3'd4:    uop = U_HX;
          3'd5:    uop = U_SY;
          3'd6:    uop = U_LW;
          default: uop = U_DONE;
        endcase
      end
      ACT_TO_WORLD, ACT_TO_BODY: begin
        case (step_q)
          3'd0:    uop = U_XC;
          3'd1:    uop = U_XS;
          3'd2:    uop = U_YC;
          3'd3:    uop = U_YS;
          default: uop = U_DONE;
        endcase
      end
      default: uop = U_DONE;
    endcase
  end

  always_comb begin
    rot_x = (act_q == ACT_FWD_WORLD) ? pr_q[0] : u_q;
    rot_y = (act_q == ACT_FWD_WORLD) ? pr_q[1] : v_q;
    x_eff = (act_q == ACT_INV_WORLD) ? mr_q[0] + mr_q[3] : u_q;
    y_eff = (act_q == ACT_INV_WORLD) ? mr_q[2] - mr_q[1] : v_q;
    opv   = '0;
    bval  = '0;
    shf   = 1'b0;
    dst_m = 1'b0;
    dix   = 2'd0;
    case (uop)
      U_DIV: begin
        opv = (v_q <<< 1) - u_q - w_q;
      end
      U_INV: begin
        opv  = w_q - u_q;
        bval = '{neg: 1'b0, mag: INV_SQRT3_Q30};
        dix  = 2'd1;
      end
      U_RTD: begin
        opv  = u_q + v_q + w_q;
        bval = '{neg: 1'b0, mag: rtd_q};
        shf  = 1'b1;
        dix  = 2'd2;
      end
      U_XC: begin
        opv   = rot_x;
        bval  = cos_q;
        dst_m = 1'b1;
      end
      U_XS: begin
        opv   = rot_x;
        bval  = sin_q;
        dst_m = 1'b1;
        dix   = 2'd1;
      end
      U_YC: begin
        opv   = rot_y;
        bval  = cos_q;
        dst_m = 1'b1;
        dix   = 2'd2;
      end
      U_YS: begin
        opv   = rot_y;
        bval  = sin_q;
        dst_m = 1'b1;
        dix   = 2'd3;
      end
      U_HX: begin
        opv  = x_eff;
        bval = '{neg: 1'b0, mag: HALF_Q30};
      end
      U_SY: begin
        opv  = y_eff;
        bval = '{neg: 1'b0, mag: SQRT3_HALF_Q30};
        dix  = 2'd1;
      end
      U_LW: begin
        opv  = w_q;
        bval = '{neg: 1'b0, mag: wd_q};
        shf  = 1'b1;
        dix  = 2'd2;
      end
      default: begin
      end
    endcase
    opabs           = opv[INT_W-1] ? -opv : opv;
    mreq.div        = uop == U_DIV;
    mreq.a_neg      = opv[INT_W-1];
    mreq.a_mag      = opabs[MA_W-1:0];
    mreq.b_neg      = bval.neg;
    mreq.b_mag      = bval.mag;
    mreq.shift_frac = shf;
  end

  assign mu_start = (st_q == S_ISSUE) && (uop != U_DONE);

  owk_serial_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mu_start),
    .req_i    (mreq),
    .busy_o   (mu_busy),
    .done_o   (mu_done),
    .result_o (mu_res)
  );

  always_comb begin
    case (act_q)
      ACT_FWD_BODY: begin
        ra_d = pr_q[0];
        rb_d = pr_q[1];
        rc_d = pr_q[2];
      end
      ACT_FWD_WORLD: begin
        ra_d = mr_q[0] - mr_q[3];
        rb_d = mr_q[1] + mr_q[2];
        rc_d = pr_q[2];
      end
      ACT_INV_BODY, ACT_INV_WORLD: begin
        ra_d = pr_q[2] - pr_q[0] - pr_q[1];
        rb_d = x_eff + pr_q[2];
        rc_d = pr_q[2] - pr_q[0] + pr_q[1];
      end
      ACT_TO_WORLD: begin
        ra_d = mr_q[0] - mr_q[3];
        rb_d = mr_q[1] + mr_q[2];
        rc_d = '0;
      end
      ACT_TO_BODY: begin
        ra_d = mr_q[0] + mr_q[3];
        rb_d = mr_q[2] - mr_q[1];
        rc_d = '0;
      end
      default: begin
        ra_d = '0;
        rb_d = '0;
        rc_d = '0;
      end
    endcase
    sat_a = sat_fn(ra_q);
    sat_b = sat_fn(rb_q);
    sat_c = sat_fn(rc_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      act_q     <= ACT_FWD_BODY;
      step_q    <= '0;
      hph_q     <= 1'b0;
      heading_q <= '0;
      sin_q     <= '0;
      cos_q     <= '{neg: 1'b0, mag: SINE_TAB[SINE_TABLE_DEPTH][MB_W-1:0]};
      wd_q      <= WHEEL_DISTANCE_RST;
      rtd_q     <= RECIP_THREE_RST;
      ov_q      <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_WHEEL_DISTANCE: wd_q  <= cfg_i.data[REG_W-1:0];
          CFG_RECIP_THREE:    rtd_q <= cfg_i.data[REG_W-1:0];
          default: begin
          end
        endcase
      end
      if (st_q == S_SAT && out_free) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
      case (st_q)
        S_IDLE: begin
          if (in_acc) begin
            act_q  <= in_i.action;
            step_q <= '0;
            hph_q  <= 1'b0;
            if (in_i.action == ACT_SET_HEADING) begin
              heading_q <= in_i.new_heading[ANGLE_BITS-1:0];
              st_q      <= S_HEAD;
            end else if (in_i.action <= ACT_TO_BODY) begin
              st_q <= S_ISSUE;
            end
          end
        end
        S_HEAD: begin
          hph_q <= 1'b1;
          if (!hph_q) begin
            sin_q <= sine_of(heading_q);
          end else begin
            cos_q <= sine_of(heading_q + ANGLE_BITS'(QUARTER));
            st_q  <= S_IDLE;
          end
        end
        S_ISSUE: st_q <= (uop == U_DONE) ? S_FIN : S_WAIT;
        S_WAIT: begin
          if (mu_done) begin
            step_q <= step_q + 1'b1;
            st_q   <= S_ISSUE;
          end
        end
        S_FIN: st_q <= S_SAT;
        S_SAT: begin
          if (out_free) begin
            st_q <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      u_q <= INT_W'(in_i.operand_a);
      v_q <= INT_W'(in_i.operand_b);
      w_q <= INT_W'(in_i.operand_c);
    end
    if (st_q == S_WAIT && mu_done) begin
      if (dst_m) begin
        mr_q[dix] <= mu_res;
      end else begin
        pr_q[dix] <= mu_res;
      end
    end
    if (st_q == S_FIN) begin
      ra_q <= ra_d;
      rb_q <= rb_d;
      rc_q <= rc_d;
    end
    if (st_q == S_SAT && out_free) begin
      oa_q   <= sat_a[DATA_WIDTH-1:0];
      ob_q   <= sat_b[DATA_WIDTH-1:0];
      oc_q   <= sat_c[DATA_WIDTH-1:0];
      osat_q <= sat_a[DATA_WIDTH] | sat_b[DATA_WIDTH] | sat_c[DATA_WIDTH];
    end
  end

  assign out_o.valid     = ov_q;
  assign out_o.result_a  = signed'(oa_q);
  assign out_o.result_b  = signed'(ob_q);
  assign out_o.result_c  = signed'(oc_q);
  assign out_o.saturated = osat_q;

  a_heading_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.action == ACT_SET_HEADING)
      |=> heading_q == $past(in_i.new_heading[ANGLE_BITS-1:0]))
    else $error("heading not taken");
  a_issue_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mu_start |=> mu_busy) else $error("serial unit did not start");
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !mu_busy) else $error("request accepted with serial unit busy");
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_SAT && out_free) |=> ov_q) else $error("result not presented");

endmodule
